// ===== rtl/core/vpcb_pkg.sv =====
`default_nettype none
package vpcb_pkg;

  localparam int ANGLE_FRAC_BITS = 4;
  localparam int CNT_SHIFT       = ANGLE_FRAC_BITS + 8;
  localparam int PROD_W          = 30;

  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int PADDR_W    = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_PAN_HI     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAN_LO     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TILT_HI    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TILT_LO    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ZOOM_HI    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ZOOM_LO    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PAN_SCALE  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TILT_SCALE = 3'd7;

  localparam logic signed [12:0] PAN_HI_RST     = 13'sd1440;
  localparam logic signed [12:0] PAN_LO_RST     = -13'sd1440;
  localparam logic signed [11:0] TILT_HI_RST    = 12'sd480;
  localparam logic signed [11:0] TILT_LO_RST    = -12'sd480;
  localparam logic [11:0]        ZOOM_HI_RST    = 12'd1024;
  localparam logic [11:0]        ZOOM_LO_RST    = 12'd0;
  localparam logic [15:0]        PAN_SCALE_RST  = 16'd2503;
  localparam logic [15:0]        TILT_SCALE_RST = 16'd2560;

  localparam logic [3:0] REQ_INIT     = 4'd0;
  localparam logic [3:0] REQ_PT_ABS   = 4'd1;
  localparam logic [3:0] REQ_PT_REL   = 4'd2;
  localparam logic [3:0] REQ_PAN_ABS  = 4'd3;
  localparam logic [3:0] REQ_TILT_ABS = 4'd4;
  localparam logic [3:0] REQ_ZOOM_ABS = 4'd5;
  localparam logic [3:0] REQ_ZOOM_REL = 4'd6;
  localparam logic [3:0] REQ_BL_ON    = 4'd7;
  localparam logic [3:0] REQ_BL_OFF   = 4'd8;

  localparam logic [7:0] B_HDR     = 8'h81;
  localparam logic [7:0] B_CMD     = 8'h01;
  localparam logic [7:0] B_PT_CAT  = 8'h06;
  localparam logic [7:0] B_PT_ABS  = 8'h02;
  localparam logic [7:0] B_PAN_SPD = 8'h18;
  localparam logic [7:0] B_TLT_SPD = 8'h14;
  localparam logic [7:0] B_CAM_CAT = 8'h04;
  localparam logic [7:0] B_ZOOM    = 8'h47;
  localparam logic [7:0] B_BL      = 8'h33;
  localparam logic [7:0] B_BL_ON   = 8'h02;
  localparam logic [7:0] B_BL_OFF  = 8'h03;
  localparam logic [7:0] B_BCAST   = 8'h88;
  localparam logic [7:0] B_ADDR    = 8'h30;
  localparam logic [7:0] B_CLEAR   = 8'h00;
  localparam logic [7:0] B_TERM    = 8'hff;

  localparam int PRE_LEN  = 9;
  localparam int PT_LEN   = 15;
  localparam int ZOOM_LEN = 9;
  localparam int BL_LEN   = 6;
  localparam int INIT_LEN = PRE_LEN + PT_LEN + ZOOM_LEN;
  localparam int IDX_W    = $clog2(INIT_LEN);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_INIT,
    CMD_PANTILT,
    CMD_ZOOM,
    CMD_BL_ON,
    CMD_BL_OFF
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] pan_cnt;
    logic [15:0] tilt_cnt;
    logic [11:0] zoom_pos;
  } cmd_t;

  typedef struct packed {
    logic [12:0] pan_limit_high;
    logic [12:0] pan_limit_low;
    logic [11:0] tilt_limit_high;
    logic [11:0] tilt_limit_low;
    logic [11:0] zoom_limit_high;
    logic [11:0] zoom_limit_low;
    logic [15:0] pan_count_scale;
    logic [15:0] tilt_count_scale;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/visca_ptz_command_builder.sv =====
// A request passes the two front stages and the command queue; its first byte is then
//   registered onto the result ports. Bytes leave one per cycle while pop is held high; a
//   request is 6 (backlight), 9 (zoom), 15 (pan-tilt) or 33 (init) bytes long.
// Requests are taken one per cycle until 4 fill the 2 front stages and command queue.
// Reset (rst, synchronous): registers to defaults, positions to 0, queue and output empty.
`default_nettype none
module visca_ptz_command_builder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [3:0]                   req_type,
  input  wire logic signed [15:0]           pan_value,
  input  wire logic signed [15:0]           tilt_value,
  input  wire logic signed [12:0]           zoom_value,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [7:0]                        out_byte,
  output logic                              packet_end,
  output logic                              last,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vpcb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  vpcb_pkg::cfg_t                 cfg;
  vpcb_pkg::cmd_t                 q_wdata;
  vpcb_pkg::cmd_t                 q_head;
  logic                           q_push;
  logic                           q_pop;
  logic                           q_nonempty;
  logic [vpcb_pkg::Q_CNT_W-1:0]   q_count;

  vpcb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vpcb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .pan_value  (pan_value),
    .tilt_value (tilt_value),
    .zoom_value (zoom_value),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  vpcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .pop      (q_pop),
    .head     (q_head),
    .nonempty (q_nonempty),
    .count    (q_count)
  );

  vpcb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .nonempty   (q_nonempty),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .packet_end (packet_end),
    .last       (last)
  );

endmodule
`default_nettype wire

// ===== rtl/core/vpcb_regs.sv =====
`default_nettype none
module vpcb_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vpcb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output vpcb_pkg::cfg_t                    cfg
);

  logic                              wr_en;
  logic [vpcb_pkg::REG_IDX_W-1:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[vpcb_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_limit_high   <= vpcb_pkg::PAN_HI_RST;
      cfg.pan_limit_low    <= vpcb_pkg::PAN_LO_RST;
      cfg.tilt_limit_high  <= vpcb_pkg::TILT_HI_RST;
      cfg.tilt_limit_low   <= vpcb_pkg::TILT_LO_RST;
      cfg.zoom_limit_high  <= vpcb_pkg::ZOOM_HI_RST;
      cfg.zoom_limit_low   <= vpcb_pkg::ZOOM_LO_RST;
      cfg.pan_count_scale  <= vpcb_pkg::PAN_SCALE_RST;
      cfg.tilt_count_scale <= vpcb_pkg::TILT_SCALE_RST;
    end else if (wr_en) begin
      unique case (idx)
        vpcb_pkg::REG_PAN_HI:     cfg.pan_limit_high   <= pwdata[12:0];
        vpcb_pkg::REG_PAN_LO:     cfg.pan_limit_low    <= pwdata[12:0];
        vpcb_pkg::REG_TILT_HI:    cfg.tilt_limit_high  <= pwdata[11:0];
        vpcb_pkg::REG_TILT_LO:    cfg.tilt_limit_low   <= pwdata[11:0];
        vpcb_pkg::REG_ZOOM_HI:    cfg.zoom_limit_high  <= pwdata[11:0];
        vpcb_pkg::REG_ZOOM_LO:    cfg.zoom_limit_low   <= pwdata[11:0];
        vpcb_pkg::REG_PAN_SCALE:  cfg.pan_count_scale  <= pwdata[15:0];
        vpcb_pkg::REG_TILT_SCALE: cfg.tilt_count_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      vpcb_pkg::REG_PAN_HI:     prdata = {19'b0, cfg.pan_limit_high};
      vpcb_pkg::REG_PAN_LO:     prdata = {19'b0, cfg.pan_limit_low};
      vpcb_pkg::REG_TILT_HI:    prdata = {20'b0, cfg.tilt_limit_high};
      vpcb_pkg::REG_TILT_LO:    prdata = {20'b0, cfg.tilt_limit_low};
      vpcb_pkg::REG_ZOOM_HI:    prdata = {20'b0, cfg.zoom_limit_high};
      vpcb_pkg::REG_ZOOM_LO:    prdata = {20'b0, cfg.zoom_limit_low};
      vpcb_pkg::REG_PAN_SCALE:  prdata = {16'b0, cfg.pan_count_scale};
      vpcb_pkg::REG_TILT_SCALE: prdata = {16'b0, cfg.tilt_count_scale};
      default:                  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/vpcb_front.sv =====
`default_nettype none
module vpcb_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire vpcb_pkg::cfg_t               cfg,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [3:0]                   req_type,
  input  wire logic signed [15:0]           pan_value,
  input  wire logic signed [15:0]           tilt_value,
  input  wire logic signed [12:0]           zoom_value,
  input  wire logic [vpcb_pkg::Q_CNT_W-1:0] q_count,
  output logic                              q_push,
  output vpcb_pkg::cmd_t                    q_data
);

  function automatic logic signed [17:0] clamp_a(input logic signed [17:0] v,
                                                 input logic signed [17:0] hi,
                                                 input logic signed [17:0] lo);
    logic signed [17:0] t;
    t = (v > hi) ? hi : v;
    return (t < lo) ? lo : t;
  endfunction

  function automatic logic [15:0] to_counts(input logic signed [vpcb_pkg::PROD_W-1:0] p);
    logic [vpcb_pkg::PROD_W-1:0] mag;
    logic [vpcb_pkg::PROD_W-1:0] r;
    mag = p[vpcb_pkg::PROD_W-1] ? vpcb_pkg::PROD_W'(-p) : vpcb_pkg::PROD_W'(p);
    r   = (mag + (vpcb_pkg::PROD_W'(1) << (vpcb_pkg::CNT_SHIFT - 1)))
          >> vpcb_pkg::CNT_SHIFT;
    return p[vpcb_pkg::PROD_W-1] ? 16'(-r[15:0]) : r[15:0];
  endfunction

  logic signed [12:0] pan_now;
  logic signed [11:0] tilt_now;
  logic        [11:0] zoom_now;

  logic               accept;
  logic               has_cmd;
  logic               upd_pt;
  logic               upd_zoom;
  vpcb_pkg::cmd_kind_t kind;
  logic signed [17:0] pan_tgt;
  logic signed [17:0] tilt_tgt;
  logic signed [17:0] zoom_tgt;
  logic signed [17:0] pan_cl;
  logic signed [17:0] tilt_cl;
  logic signed [17:0] zoom_cl;
  logic [vpcb_pkg::Q_CNT_W-1:0] in_flight;

  logic                s1_valid;
  vpcb_pkg::cmd_kind_t s1_kind;
  logic signed [12:0]  s1_pan;
  logic signed [11:0]  s1_tilt;
  logic [11:0]         s1_zoom;

  logic                s2_valid;
  vpcb_pkg::cmd_kind_t s2_kind;
  logic signed [vpcb_pkg::PROD_W-1:0] s2_pan_prod;
  logic signed [vpcb_pkg::PROD_W-1:0] s2_tilt_prod;
  logic [11:0]         s2_zoom;

  logic signed [vpcb_pkg::PROD_W-1:0] pan_prod;
  logic signed [vpcb_pkg::PROD_W-1:0] tilt_prod;

  // queue space is reserved for items still in the two front stages
  assign in_flight = q_count + vpcb_pkg::Q_CNT_W'(s1_valid) + vpcb_pkg::Q_CNT_W'(s2_valid);
  assign full      = (in_flight >= vpcb_pkg::Q_CNT_W'(vpcb_pkg::Q_DEPTH));
  assign accept    = push && !full;

  always_comb begin
    has_cmd  = 1'b1;
    upd_pt   = 1'b0;
    upd_zoom = 1'b0;
    kind     = vpcb_pkg::CMD_PANTILT;
    pan_tgt  = 18'(pan_now);
    tilt_tgt = 18'(tilt_now);
    zoom_tgt = 18'($signed({1'b0, zoom_now}));
    unique case (req_type)
      vpcb_pkg::REQ_INIT: begin
        kind     = vpcb_pkg::CMD_INIT;
        upd_pt   = 1'b1;
        upd_zoom = 1'b1;
        pan_tgt  = '0;
        tilt_tgt = '0;
        zoom_tgt = '0;
      end
      vpcb_pkg::REQ_PT_ABS: begin
        upd_pt   = 1'b1;
        pan_tgt  = 18'(pan_value);
        tilt_tgt = 18'(tilt_value);
      end
      vpcb_pkg::REQ_PT_REL: begin
        upd_pt   = 1'b1;
        pan_tgt  = 18'(pan_now) + 18'(pan_value);
        tilt_tgt = 18'(tilt_now) + 18'(tilt_value);
      end
      vpcb_pkg::REQ_PAN_ABS: begin
        upd_pt  = 1'b1;
        pan_tgt = 18'(pan_value);
      end
      vpcb_pkg::REQ_TILT_ABS: begin
        upd_pt   = 1'b1;
        tilt_tgt = 18'(tilt_value);
      end
      vpcb_pkg::REQ_ZOOM_ABS: begin
        kind     = vpcb_pkg::CMD_ZOOM;
        upd_zoom = 1'b1;
        zoom_tgt = 18'(zoom_value);
      end
      vpcb_pkg::REQ_ZOOM_REL: begin
        kind     = vpcb_pkg::CMD_ZOOM;
        upd_zoom = 1'b1;
        zoom_tgt = 18'($signed({1'b0, zoom_now})) + 18'(zoom_value);
      end
      vpcb_pkg::REQ_BL_ON:  kind = vpcb_pkg::CMD_BL_ON;
      vpcb_pkg::REQ_BL_OFF: kind = vpcb_pkg::CMD_BL_OFF;
      default: has_cmd = 1'b0;
    endcase
  end

  assign pan_cl  = clamp_a(pan_tgt, 18'($signed(cfg.pan_limit_high)),
                           18'($signed(cfg.pan_limit_low)));
  assign tilt_cl = clamp_a(tilt_tgt, 18'($signed(cfg.tilt_limit_high)),
                           18'($signed(cfg.tilt_limit_low)));
  assign zoom_cl = clamp_a(zoom_tgt, 18'($signed({1'b0, cfg.zoom_limit_high})),
                           18'($signed({1'b0, cfg.zoom_limit_low})));

  assign pan_prod  = vpcb_pkg::PROD_W'(s1_pan)
                   * vpcb_pkg::PROD_W'($signed({1'b0, cfg.pan_count_scale}));
  assign tilt_prod = vpcb_pkg::PROD_W'(s1_tilt)
                   * vpcb_pkg::PROD_W'($signed({1'b0, cfg.tilt_count_scale}));

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_now  <= '0;
      tilt_now <= '0;
      zoom_now <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept && has_cmd;
      s2_valid <= s1_valid;
      if (accept && upd_pt) begin
        pan_now  <= pan_cl[12:0];
        tilt_now <= tilt_cl[11:0];
      end
      if (accept && upd_zoom) begin
        zoom_now <= zoom_cl[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_kind      <= kind;
    s1_pan       <= pan_cl[12:0];
    s1_tilt      <= tilt_cl[11:0];
    s1_zoom      <= zoom_cl[11:0];
    s2_kind      <= s1_kind;
    s2_pan_prod  <= pan_prod;
    s2_tilt_prod <= tilt_prod;
    s2_zoom      <= s1_zoom;
  end

  assign q_push          = s2_valid;
  assign q_data.kind     = s2_kind;
  assign q_data.pan_cnt  = to_counts(s2_pan_prod);
  assign q_data.tilt_cnt = to_counts(s2_tilt_prod);
  assign q_data.zoom_pos = s2_zoom;

  a_no_overbook: assert property (@(posedge clk) disable iff (rst)
    in_flight <= vpcb_pkg::Q_CNT_W'(vpcb_pkg::Q_DEPTH))
    else $error("front holds more items than the queue can take");

endmodule
`default_nettype wire

// ===== rtl/core/vpcb_queue.sv =====
`default_nettype none
module vpcb_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire vpcb_pkg::cmd_t               wdata,
  input  wire logic                         pop,
  output vpcb_pkg::cmd_t                    head,
  output logic                              nonempty,
  output logic [vpcb_pkg::Q_CNT_W-1:0]      count
);

  vpcb_pkg::cmd_t                 mem [vpcb_pkg::Q_DEPTH];
  logic [vpcb_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [vpcb_pkg::Q_PTR_W-1:0]   rd_ptr;

  function automatic logic [vpcb_pkg::Q_PTR_W-1:0] ptr_inc(
      input logic [vpcb_pkg::Q_PTR_W-1:0] p);
    return (p == vpcb_pkg::Q_PTR_W'(vpcb_pkg::Q_DEPTH - 1))
           ? '0 : vpcb_pkg::Q_PTR_W'(p + 1'b1);
  endfunction

  assign head     = mem[rd_ptr];
  assign nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != vpcb_pkg::Q_CNT_W'(vpcb_pkg::Q_DEPTH)))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("command queue underflow");

endmodule
`default_nettype wire

// ===== rtl/core/vpcb_back.sv =====
`default_nettype none
module vpcb_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire vpcb_pkg::cmd_t head,
  input  wire logic           nonempty,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output logic [7:0]          out_byte,
  output logic                packet_end,
  output logic                last
);

  function automatic logic [7:0] pt_byte(input logic [3:0] i, input logic [15:0] p,
                                         input logic [15:0] t);
    logic [7:0] b;
    case (i)
      4'd0:    b = vpcb_pkg::B_HDR;
      4'd1:    b = vpcb_pkg::B_CMD;
      4'd2:    b = vpcb_pkg::B_PT_CAT;
      4'd3:    b = vpcb_pkg::B_PT_ABS;
      4'd4:    b = vpcb_pkg::B_PAN_SPD;
      4'd5:    b = vpcb_pkg::B_TLT_SPD;
      4'd6:    b = {4'h0, p[15:12]};
      4'd7:    b = {4'h0, p[11:8]};
      4'd8:    b = {4'h0, p[7:4]};
      4'd9:    b = {4'h0, p[3:0]};
      4'd10:   b = {4'h0, t[15:12]};
      4'd11:   b = {4'h0, t[11:8]};
      4'd12:   b = {4'h0, t[7:4]};
      4'd13:   b = {4'h0, t[3:0]};
      default: b = vpcb_pkg::B_TERM;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] zoom_byte(input logic [3:0] i, input logic [11:0] z);
    logic [7:0] b;
    case (i)
      4'd0:    b = vpcb_pkg::B_HDR;
      4'd1:    b = vpcb_pkg::B_CMD;
      4'd2:    b = vpcb_pkg::B_CAM_CAT;
      4'd3:    b = vpcb_pkg::B_ZOOM;
      4'd4:    b = 8'h00;
      4'd5:    b = {4'h0, z[11:8]};
      4'd6:    b = {4'h0, z[7:4]};
      4'd7:    b = {4'h0, z[3:0]};
      default: b = vpcb_pkg::B_TERM;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bl_byte(input logic [3:0] i, input logic [7:0] mode);
    logic [7:0] b;
    case (i)
      4'd0:    b = vpcb_pkg::B_HDR;
      4'd1:    b = vpcb_pkg::B_CMD;
      4'd2:    b = vpcb_pkg::B_CAM_CAT;
      4'd3:    b = vpcb_pkg::B_BL;
      4'd4:    b = mode;
      default: b = vpcb_pkg::B_TERM;
    endcase
    return b;
  endfunction

  // if-clear broadcast then address set
  function automatic logic [7:0] pre_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:    b = vpcb_pkg::B_BCAST;
      4'd1:    b = vpcb_pkg::B_CMD;
      4'd2:    b = vpcb_pkg::B_CLEAR;
      4'd3:    b = vpcb_pkg::B_CMD;
      4'd5:    b = vpcb_pkg::B_BCAST;
      4'd6:    b = vpcb_pkg::B_ADDR;
      4'd7:    b = vpcb_pkg::B_CMD;
      default: b = vpcb_pkg::B_TERM;
    endcase
    return b;
  endfunction

  logic [vpcb_pkg::IDX_W-1:0] idx;
  logic [vpcb_pkg::IDX_W-1:0] len;
  logic [vpcb_pkg::IDX_W-1:0] seg_pt;
  logic [vpcb_pkg::IDX_W-1:0] seg_zoom;
  logic [7:0]                 byte_next;
  logic                       last_next;
  logic                       advance;
  logic                       o_valid;

  assign seg_pt   = vpcb_pkg::IDX_W'(idx - vpcb_pkg::IDX_W'(vpcb_pkg::PRE_LEN));
  assign seg_zoom = vpcb_pkg::IDX_W'(idx - vpcb_pkg::IDX_W'(vpcb_pkg::PRE_LEN
                                                          + vpcb_pkg::PT_LEN));

  always_comb begin
    case (head.kind)
      vpcb_pkg::CMD_INIT: begin
        len = vpcb_pkg::IDX_W'(vpcb_pkg::INIT_LEN);
        if (idx < vpcb_pkg::IDX_W'(vpcb_pkg::PRE_LEN))
          byte_next = pre_byte(idx[3:0]);
        else if (idx < vpcb_pkg::IDX_W'(vpcb_pkg::PRE_LEN + vpcb_pkg::PT_LEN))
          byte_next = pt_byte(seg_pt[3:0], head.pan_cnt, head.tilt_cnt);
        else
          byte_next = zoom_byte(seg_zoom[3:0], head.zoom_pos);
      end
      vpcb_pkg::CMD_PANTILT: begin
        len       = vpcb_pkg::IDX_W'(vpcb_pkg::PT_LEN);
        byte_next = pt_byte(idx[3:0], head.pan_cnt, head.tilt_cnt);
      end
      vpcb_pkg::CMD_ZOOM: begin
        len       = vpcb_pkg::IDX_W'(vpcb_pkg::ZOOM_LEN);
        byte_next = zoom_byte(idx[3:0], head.zoom_pos);
      end
      vpcb_pkg::CMD_BL_ON: begin
        len       = vpcb_pkg::IDX_W'(vpcb_pkg::BL_LEN);
        byte_next = bl_byte(idx[3:0], vpcb_pkg::B_BL_ON);
      end
      default: begin
        len       = vpcb_pkg::IDX_W'(vpcb_pkg::BL_LEN);
        byte_next = bl_byte(idx[3:0], vpcb_pkg::B_BL_OFF);
      end
    endcase
  end

  assign last_next = (idx == vpcb_pkg::IDX_W'(len - 1'b1));
  assign advance   = nonempty && (!o_valid || pop);
  assign q_pop     = advance && last_next;
  assign empty     = !o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
      idx     <= last_next ? '0 : vpcb_pkg::IDX_W'(idx + 1'b1);
    end else if (pop) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= byte_next;
      packet_end <= (byte_next == vpcb_pkg::B_TERM);
      last       <= last_next;
    end
  end

  a_last_ends_packet: assert property (@(posedge clk) disable iff (rst)
    (o_valid && last) |-> packet_end)
    else $error("final byte of a request is not a terminator");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    nonempty |-> (idx < len))
    else $error("byte index ran past the packet length");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_CYCLES = 400;
  localparam int IDLE_PCT     = 15;

  localparam logic [3:0] REQ_FIRST_UNKNOWN = 4'd9;
  localparam logic [3:0] REQ_LAST_UNKNOWN  = 4'd15;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_term;
    logic       is_last;
  } cam_byte_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [3:0]          req_type = '0;
  logic signed [15:0]  pan_value = '0;
  logic signed [15:0]  tilt_value = '0;
  logic signed [12:0]  zoom_value = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [7:0]          out_byte;
  logic                packet_end;
  logic                last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [vpcb_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  always #5 clk = ~clk;

  visca_ptz_command_builder dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .pan_value  (pan_value),
    .tilt_value (tilt_value),
    .zoom_value (zoom_value),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .packet_end (packet_end),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Mirror of the block's registers and positions
  vpcb_pkg::cfg_t     cfg;
  logic signed [12:0] pan_pos;
  logic signed [11:0] tilt_pos;
  logic [11:0]        zoom_pos;

  cam_byte_t pending_bytes[$];
  cam_byte_t want_byte;

  int  errors = 0;
  int  requests_sent = 0;
  int  requests_ignored = 0;
  int  bytes_checked = 0;
  int  config_count = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  bit  stall_go = 1'b0;
  bit  stall_done = 1'b0;
  int  stall_left = 0;

  function automatic int clamp_to(int v, int hi, int lo);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // Q8.8 counts per degree, rounded half away from zero, low 16 bits kept
  function automatic logic [15:0] angle_to_counts(int angle, logic [15:0] scale);
    longint prod;
    longint mag;
    longint r;
    prod = longint'(angle) * longint'(scale);
    mag  = (prod < 0) ? -prod : prod;
    r    = (mag + longint'(1 << (vpcb_pkg::CNT_SHIFT - 1))) >> vpcb_pkg::CNT_SHIFT;
    if (prod < 0) r = -r;
    return 16'(r);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic term);
    pending_bytes.push_back('{b, term, 1'b0});
  endfunction

  function automatic void add_nibbles(logic [15:0] v);
    add_byte({4'h0, v[15:12]}, 1'b0);
    add_byte({4'h0, v[11:8]}, 1'b0);
    add_byte({4'h0, v[7:4]}, 1'b0);
    add_byte({4'h0, v[3:0]}, 1'b0);
  endfunction

  function automatic void emit_pan_tilt(int pan_t, int tilt_t);
    int hi;
    int lo;
    hi = $signed(cfg.pan_limit_high);
    lo = $signed(cfg.pan_limit_low);
    pan_pos = 13'(clamp_to(pan_t, hi, lo));
    hi = $signed(cfg.tilt_limit_high);
    lo = $signed(cfg.tilt_limit_low);
    tilt_pos = 12'(clamp_to(tilt_t, hi, lo));
    add_byte(vpcb_pkg::B_HDR, 1'b0);
    add_byte(vpcb_pkg::B_CMD, 1'b0);
    add_byte(vpcb_pkg::B_PT_CAT, 1'b0);
    add_byte(vpcb_pkg::B_PT_ABS, 1'b0);
    add_byte(vpcb_pkg::B_PAN_SPD, 1'b0);
    add_byte(vpcb_pkg::B_TLT_SPD, 1'b0);
    add_nibbles(angle_to_counts(pan_pos, cfg.pan_count_scale));
    add_nibbles(angle_to_counts(tilt_pos, cfg.tilt_count_scale));
    add_byte(vpcb_pkg::B_TERM, 1'b1);
  endfunction

  function automatic void emit_zoom(int z);
    int hi;
    int lo;
    hi = cfg.zoom_limit_high;
    lo = cfg.zoom_limit_low;
    zoom_pos = 12'(clamp_to(z, hi, lo));
    add_byte(vpcb_pkg::B_HDR, 1'b0);
    add_byte(vpcb_pkg::B_CMD, 1'b0);
    add_byte(vpcb_pkg::B_CAM_CAT, 1'b0);
    add_byte(vpcb_pkg::B_ZOOM, 1'b0);
    add_nibbles({4'h0, zoom_pos});
    add_byte(vpcb_pkg::B_TERM, 1'b1);
  endfunction

  function automatic void emit_backlight(logic [7:0] mode);
    add_byte(vpcb_pkg::B_HDR, 1'b0);
    add_byte(vpcb_pkg::B_CMD, 1'b0);
    add_byte(vpcb_pkg::B_CAM_CAT, 1'b0);
    add_byte(vpcb_pkg::B_BL, 1'b0);
    add_byte(mode, 1'b0);
    add_byte(vpcb_pkg::B_TERM, 1'b1);
  endfunction

  // Returns 0 for request types the block ignores
  function automatic bit encode_request(logic [3:0] req, int pv, int tv, int zv);
    cam_byte_t tail;
    bit        produced;
    produced = 1'b1;
    case (req)
      vpcb_pkg::REQ_INIT: begin
        add_byte(vpcb_pkg::B_BCAST, 1'b0);
        add_byte(vpcb_pkg::B_CMD, 1'b0);
        add_byte(vpcb_pkg::B_CLEAR, 1'b0);
        add_byte(vpcb_pkg::B_CMD, 1'b0);
        add_byte(vpcb_pkg::B_TERM, 1'b1);
        add_byte(vpcb_pkg::B_BCAST, 1'b0);
        add_byte(vpcb_pkg::B_ADDR, 1'b0);
        add_byte(vpcb_pkg::B_CMD, 1'b0);
        add_byte(vpcb_pkg::B_TERM, 1'b1);
        emit_pan_tilt(0, 0);
        emit_zoom(0);
      end
      vpcb_pkg::REQ_PT_ABS:   emit_pan_tilt(pv, tv);
      vpcb_pkg::REQ_PT_REL:   emit_pan_tilt(int'(pan_pos) + pv, int'(tilt_pos) + tv);
      vpcb_pkg::REQ_PAN_ABS:  emit_pan_tilt(pv, tilt_pos);
      vpcb_pkg::REQ_TILT_ABS: emit_pan_tilt(pan_pos, tv);
      vpcb_pkg::REQ_ZOOM_ABS: emit_zoom(zv);
      vpcb_pkg::REQ_ZOOM_REL: emit_zoom(int'(zoom_pos) + zv);
      vpcb_pkg::REQ_BL_ON:    emit_backlight(vpcb_pkg::B_BL_ON);
      vpcb_pkg::REQ_BL_OFF:   emit_backlight(vpcb_pkg::B_BL_OFF);
      default:                produced = 1'b0;
    endcase
    if (produced) begin
      tail = pending_bytes.pop_back();
      tail.is_last = 1'b1;
      pending_bytes.push_back(tail);
    end
    return produced;
  endfunction

  task automatic send_request(logic [3:0] rt, logic [15:0] pv, logic [15:0] tv,
                              logic [12:0] zv);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    push       <= 1'b1;
    req_type   <= rt;
    pan_value  <= pv;
    tilt_value <= tv;
    zoom_value <= zv;
    do @(posedge clk); while (full);
    if (encode_request(rt, $signed(pv), $signed(tv), $signed(zv))) requests_sent++;
    else requests_ignored++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves psel/penable up between back-to-back writes; each write takes effect once
  task automatic write_reg(logic [vpcb_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_config(vpcb_pkg::cfg_t c);
    write_reg(vpcb_pkg::REG_PAN_HI, 32'(c.pan_limit_high));
    write_reg(vpcb_pkg::REG_PAN_LO, 32'(c.pan_limit_low));
    write_reg(vpcb_pkg::REG_TILT_HI, 32'(c.tilt_limit_high));
    write_reg(vpcb_pkg::REG_TILT_LO, 32'(c.tilt_limit_low));
    write_reg(vpcb_pkg::REG_ZOOM_HI, 32'(c.zoom_limit_high));
    write_reg(vpcb_pkg::REG_ZOOM_LO, 32'(c.zoom_limit_low));
    write_reg(vpcb_pkg::REG_PAN_SCALE, 32'(c.pan_count_scale));
    write_reg(vpcb_pkg::REG_TILT_SCALE, 32'(c.tilt_count_scale));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg = c;
    config_count++;
  endtask

  function automatic vpcb_pkg::cfg_t random_config();
    vpcb_pkg::cfg_t c;
    int   a;
    int   b;
    if ($urandom_range(4) == 0) begin
      c.pan_limit_high   = 13'($urandom);
      c.pan_limit_low    = 13'($urandom);
      c.tilt_limit_high  = 12'($urandom);
      c.tilt_limit_low   = 12'($urandom);
      c.zoom_limit_high  = 12'($urandom);
      c.zoom_limit_low   = 12'($urandom);
      c.pan_count_scale  = 16'($urandom);
      c.tilt_count_scale = 16'($urandom);
    end else begin
      a = $urandom_range(5760);
      a -= 2880;
      b = $urandom_range(5760);
      b -= 2880;
      c.pan_limit_high = 13'((a > b) ? a : b);
      c.pan_limit_low  = 13'((a > b) ? b : a);
      a = $urandom_range(2880);
      a -= 1440;
      b = $urandom_range(2880);
      b -= 1440;
      c.tilt_limit_high = 12'((a > b) ? a : b);
      c.tilt_limit_low  = 12'((a > b) ? b : a);
      a = $urandom_range(4095);
      b = $urandom_range(4095);
      c.zoom_limit_high  = 12'((a > b) ? a : b);
      c.zoom_limit_low   = 12'((a > b) ? b : a);
      c.pan_count_scale  = 16'($urandom_range(4000, 500));
      c.tilt_count_scale = 16'($urandom_range(4000, 500));
    end
    return c;
  endfunction

  function automatic logic [15:0] random_angle();
    if ($urandom_range(1) == 0) return 16'($urandom);
    return 16'($urandom_range(7000) - 3500);
  endfunction

  function automatic logic [12:0] random_zoom();
    if ($urandom_range(1) == 0) return 13'($urandom);
    return 13'($urandom_range(4400) - 200);
  endfunction

  task automatic send_random_request();
    int         pick;
    logic [3:0] rt;
    pick = $urandom_range(99);
    if (pick < 4) rt = vpcb_pkg::REQ_INIT;
    else if (pick < 20) rt = vpcb_pkg::REQ_PT_ABS;
    else if (pick < 32) rt = vpcb_pkg::REQ_PT_REL;
    else if (pick < 42) rt = vpcb_pkg::REQ_PAN_ABS;
    else if (pick < 52) rt = vpcb_pkg::REQ_TILT_ABS;
    else if (pick < 64) rt = vpcb_pkg::REQ_ZOOM_ABS;
    else if (pick < 76) rt = vpcb_pkg::REQ_ZOOM_REL;
    else if (pick < 82) rt = vpcb_pkg::REQ_BL_ON;
    else if (pick < 88) rt = vpcb_pkg::REQ_BL_OFF;
    else rt = 4'($urandom_range(REQ_LAST_UNKNOWN, REQ_FIRST_UNKNOWN));
    send_request(rt, random_angle(), random_angle(), random_zoom());
  endtask

  task automatic test_default_directed();
    send_request(vpcb_pkg::REQ_INIT, $urandom, $urandom, $urandom);
    send_request(vpcb_pkg::REQ_PT_ABS, 16'h7fff, 16'h8000, $urandom);
    send_request(vpcb_pkg::REQ_PT_ABS, 16'h8000, 16'h7fff, $urandom);
    // tilt of +/-4 gives an exact half count, which rounds away from zero
    send_request(vpcb_pkg::REQ_PT_ABS, 16'd8, 16'd4, $urandom);
    send_request(vpcb_pkg::REQ_PT_ABS, -16'sd8, -16'sd4, $urandom);
    send_request(vpcb_pkg::REQ_PT_REL, 16'd300, -16'sd200, $urandom);
    send_request(vpcb_pkg::REQ_PT_REL, 16'h7fff, 16'h7fff, $urandom);
    send_request(vpcb_pkg::REQ_PT_REL, 16'h8000, 16'h8000, $urandom);
    send_request(vpcb_pkg::REQ_PAN_ABS, 16'd1441, $urandom, $urandom);
    send_request(vpcb_pkg::REQ_TILT_ABS, $urandom, -16'sd481, $urandom);
    send_request(vpcb_pkg::REQ_ZOOM_ABS, $urandom, $urandom, 13'h0fff);
    send_request(vpcb_pkg::REQ_ZOOM_ABS, $urandom, $urandom, 13'h1000);
    send_request(vpcb_pkg::REQ_ZOOM_ABS, $urandom, $urandom, 13'd700);
    send_request(vpcb_pkg::REQ_ZOOM_REL, $urandom, $urandom, 13'd500);
    send_request(vpcb_pkg::REQ_ZOOM_REL, $urandom, $urandom, 13'h1000);
    send_request(vpcb_pkg::REQ_ZOOM_REL, $urandom, $urandom, 13'd300);
    send_request(vpcb_pkg::REQ_BL_ON, $urandom, $urandom, $urandom);
    send_request(vpcb_pkg::REQ_BL_OFF, $urandom, $urandom, $urandom);
    send_request(REQ_FIRST_UNKNOWN, $urandom, $urandom, $urandom);
    send_request(REQ_LAST_UNKNOWN, $urandom, $urandom, $urandom);
    send_request(vpcb_pkg::REQ_INIT, $urandom, $urandom, $urandom);
  endtask

  task automatic test_limit_extremes();
    wait_idle();
    apply_config('{13'h0fff, 13'h1000, 12'h7ff, 12'h800, 12'hfff, 12'h000,
                   16'hffff, 16'hffff});
    send_request(vpcb_pkg::REQ_PT_ABS, 16'h7fff, 16'h7fff, $urandom);
    send_request(vpcb_pkg::REQ_PT_ABS, 16'h8000, 16'h8000, $urandom);
    send_request(vpcb_pkg::REQ_PT_REL, 16'h7fff, 16'h0001, $urandom);
    send_request(vpcb_pkg::REQ_ZOOM_ABS, $urandom, $urandom, 13'h0fff);
    send_request(vpcb_pkg::REQ_ZOOM_REL, $urandom, $urandom, 13'h1000);
    send_request(vpcb_pkg::REQ_INIT, $urandom, $urandom, $urandom);
    // zero scale: counts stay 0
    wait_idle();
    apply_config('{13'h0fff, 13'h1000, 12'h7ff, 12'h800, 12'hfff, 12'h000,
                   16'h0000, 16'h0000});
    send_request(vpcb_pkg::REQ_PT_ABS, 16'd2000, -16'sd1200, $urandom);
    send_request(vpcb_pkg::REQ_PT_REL, -16'sd5000, 16'd700, $urandom);
    // inverted limits: low limit wins
    wait_idle();
    apply_config('{-13'sd100, 13'sd200, -12'sd50, 12'sd50, 12'd10, 12'd3000,
                   16'd2503, 16'd2560});
    send_request(vpcb_pkg::REQ_PT_ABS, -16'sd3000, 16'd3000, $urandom);
    send_request(vpcb_pkg::REQ_PT_ABS, 16'd3000, -16'sd3000, $urandom);
    send_request(vpcb_pkg::REQ_PAN_ABS, 16'd150, $urandom, $urandom);
    send_request(vpcb_pkg::REQ_TILT_ABS, $urandom, -16'sd20, $urandom);
    send_request(vpcb_pkg::REQ_ZOOM_ABS, $urandom, $urandom, 13'd0);
    send_request(vpcb_pkg::REQ_ZOOM_ABS, $urandom, $urandom, 13'd4000);
    send_request(vpcb_pkg::REQ_INIT, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_traffic(int n, bit quiet);
    int start;
    wait_idle();
    apply_config(random_config());
    no_idle = quiet;
    start = requests_sent;
    while (requests_sent - start < n) send_random_request();
    no_idle = 1'b0;
  endtask

  // output held off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    wait_idle();
    apply_config(random_config());
    stall_go <= 1'b1;
    repeat (40) send_random_request();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_bytes.size() == 0) begin
          $error("byte %h transferred with no request pending", out_byte);
          errors++;
        end else begin
          want_byte = pending_bytes.pop_front();
          bytes_checked++;
          if (out_byte !== want_byte.byte_val) begin
            $error("out_byte: expected %h, got %h", want_byte.byte_val, out_byte);
            errors++;
          end
          if (packet_end !== want_byte.is_term) begin
            $error("packet_end: expected %b, got %b", want_byte.is_term, packet_end);
            errors++;
          end
          if (last !== want_byte.is_last) begin
            $error("last: expected %b, got %b", want_byte.is_last, last);
            errors++;
          end
        end
      end
      if (stall_go && !stall_done) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (no_idle) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    cfg = '{vpcb_pkg::PAN_HI_RST, vpcb_pkg::PAN_LO_RST, vpcb_pkg::TILT_HI_RST,
            vpcb_pkg::TILT_LO_RST, vpcb_pkg::ZOOM_HI_RST, vpcb_pkg::ZOOM_LO_RST,
            vpcb_pkg::PAN_SCALE_RST, vpcb_pkg::TILT_SCALE_RST};
    pan_pos  = '0;
    tilt_pos = '0;
    zoom_pos = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_directed();
    test_limit_extremes();
    test_random_traffic(100, 1'b0);
    test_random_traffic(80, 1'b1);
    test_random_traffic(100, 1'b0);
    test_backpressure();
    test_random_traffic(110, 1'b0);
    wait_idle();
    $display("Checked %0d camera bytes from %0d requests, %0d unknown types dropped.",
             bytes_checked, requests_sent, requests_ignored);
    $display("Register settings: %0d, incl. widest, zero-scale and inverted limits.",
             config_count);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
